>>> src/bmsf_pkg.sv
// ----------------------------------------------------------------------------
// bmsf_pkg: shared constants and types
// Sizes of the heap bitmap, field widths and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bmsf_pkg;

	localparam int MAX_SLOTS        = 4096;
	localparam int MAX_OBJECT_SLOTS = 256;
	localparam int WORD_W           = 32;
	localparam int BIT_W            = $clog2(WORD_W);
	localparam int CNT_W            = BIT_W + 1;
	localparam int WORD_COUNT       = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int WIDX_W           = $clog2(WORD_COUNT);
	localparam int SLOT_W           = 13;
	localparam int START_W          = 12;
	localparam int LEN_W            = 9;

	localparam logic [WORD_W-1:0] WORD_ONES = '1;

	localparam logic OP_MARK  = 1'b0;
	localparam logic OP_SWEEP = 1'b1;

	typedef struct packed {
		logic accept;
		logic mk_wr;
		logic scan;
		logic run;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic in_op;
		logic in_short;
		logic mark_last;
		logic found;
		logic at_end;
		logic out_free;
	} sts_t;

endpackage

>>> src/bmsf_in_if.sv
// ----------------------------------------------------------------------------
// bmsf_in_if: input word channel
// Carries one mark or sweep request with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bmsf_in_if;

	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [bmsf_pkg::START_W-1:0]   start_slot;
	logic [bmsf_pkg::LEN_W-1:0]     length;

	modport source (output valid, output operation, output start_slot, output length,
		input ready);
	modport sink (input valid, input operation, input start_slot, input length,
		output ready);

endinterface

>>> src/bmsf_out_if.sv
// ----------------------------------------------------------------------------
// bmsf_out_if: result word channel
// Carries one result per request with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bmsf_out_if;

	logic                           valid;
	logic                           ready;
	logic                           run_valid;
	logic [bmsf_pkg::START_W-1:0]   run_start;
	logic [bmsf_pkg::SLOT_W-1:0]    run_length;
	logic                           sweep_done;
	logic [bmsf_pkg::SLOT_W-1:0]    free_total;
	logic                           off_heap;

	modport source (output valid, output run_valid, output run_start, output run_length,
		output sweep_done, output free_total, output off_heap, input ready);
	modport sink (input valid, input run_valid, input run_start, input run_length,
		input sweep_done, input free_total, input off_heap, output ready);

endinterface

>>> src/bitmap_mark_sweep_free_runs.sv
// ----------------------------------------------------------------------------
// bitmap_mark_sweep_free_runs: mark-sweep liveness bitmap with free runs
// Keeps one live bit per heap slot, marks slot runs live and sweeps out the
// next run of free slots on each sweep request.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result word for it.
// The bitmap sits in a single-port memory of 128 words of 32 bits with a
// registered read, so each bitmap word is read in one state and written or
// scanned in the next. A mark visits each bitmap word the run touches (at most
// nine); an off-heap or empty mark goes straight to its result. A sweep visits
// the words it passes while skipping live slots and then those it passes while
// counting the free run, the word in which the run begins counting in both. A
// result word held back by the sink stalls the block until the output register
// is free. Reset clears the bitmap at once through per-word valid bits, so no
// clearing pass follows reset. A new request is taken while the previous
// result word still waits in the output register.
module bitmap_mark_sweep_free_runs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bmsf_pkg::SLOT_W-1:0] cfg_data,
	bmsf_in_if.sink                     in_word,
	bmsf_out_if.source                  out_word
);

	bmsf_pkg::cmd_t cmd;
	bmsf_pkg::sts_t sts;
	logic           in_ready;

	assign in_word.ready = in_ready;

	bmsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_word.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmsf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.operation  (in_word.operation),
		.start_slot (in_word.start_slot),
		.length     (in_word.length),
		.cmd        (cmd),
		.sts        (sts),
		.out_word   (out_word)
	);

endmodule

>>> src/bmsf_find.sv
// ----------------------------------------------------------------------------
// bmsf_find: bit search within one bitmap word
// Finds the lowest bit at or above a start position and below a limit that
// matches the wanted polarity.
// ----------------------------------------------------------------------------
module bmsf_find (
	input  logic [bmsf_pkg::WORD_W-1:0] data,
	input  logic [bmsf_pkg::BIT_W-1:0]  lo,
	input  logic [bmsf_pkg::CNT_W-1:0]  cnt,
	input  logic                        target,
	output logic                        found,
	output logic [bmsf_pkg::BIT_W-1:0]  idx
);

	logic [bmsf_pkg::WORD_W-1:0] cand;

	assign cand = (target ? data : ~data)
		& (bmsf_pkg::WORD_ONES << lo)
		& ~(bmsf_pkg::WORD_ONES << cnt);

	assign found = |cand;

	always_comb begin
		idx = '0;
		for (int i = bmsf_pkg::WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				idx = bmsf_pkg::BIT_W'(i);
			end
		end
	end

endmodule

>>> src/bmsf_dp.sv
// ----------------------------------------------------------------------------
// bmsf_dp: bitmap datapath
// Holds the bitmap memory with its per-word valid bits, the sweep cursor,
// the free total, the size register and the result register.
// ----------------------------------------------------------------------------
module bmsf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bmsf_pkg::SLOT_W-1:0]   cfg_data,
	input  logic                          operation,
	input  logic [bmsf_pkg::START_W-1:0]  start_slot,
	input  logic [bmsf_pkg::LEN_W-1:0]    length,
	input  bmsf_pkg::cmd_t                cmd,
	output bmsf_pkg::sts_t                sts,
	bmsf_out_if.source                    out_word
);

	logic [bmsf_pkg::WORD_W-1:0]     mem [bmsf_pkg::WORD_COUNT];
	logic [bmsf_pkg::WORD_W-1:0]     rdata_q;
	logic [bmsf_pkg::WORD_COUNT-1:0] valid_q;

	logic [bmsf_pkg::SLOT_W-1:0]     num_slots_q;
	logic [bmsf_pkg::SLOT_W-1:0]     cursor_q;
	logic [bmsf_pkg::SLOT_W-1:0]     free_q;
	logic [bmsf_pkg::WIDX_W-1:0]     w_q;
	logic [bmsf_pkg::START_W-1:0]    mark_s_q;
	logic [bmsf_pkg::SLOT_W-1:0]     mark_e_q;
	logic [bmsf_pkg::START_W-1:0]    rstart_q;
	logic [bmsf_pkg::SLOT_W-1:0]     rlen_q;
	logic                            res_valid_q;
	logic                            res_done_q;
	logic                            res_offh_q;

	logic                            out_valid_q;
	logic                            run_valid_q;
	logic [bmsf_pkg::START_W-1:0]    run_start_q;
	logic [bmsf_pkg::SLOT_W-1:0]     run_length_q;
	logic                            sweep_done_q;
	logic [bmsf_pkg::SLOT_W-1:0]     free_total_q;
	logic                            off_heap_q;

	logic [bmsf_pkg::SLOT_W-1:0]     size;
	logic [bmsf_pkg::SLOT_W-1:0]     s_ext;
	logic [bmsf_pkg::LEN_W-1:0]      len_sat;
	logic [bmsf_pkg::SLOT_W-1:0]     s_plus;
	logic [bmsf_pkg::SLOT_W-1:0]     e_new;
	logic                            off;
	logic                            cursor_end;
	logic [bmsf_pkg::WIDX_W-1:0]     end_w;

	logic [bmsf_pkg::WORD_W-1:0]     word;
	logic [bmsf_pkg::SLOT_W-1:0]     em1;
	logic                            mark_last;
	logic [bmsf_pkg::BIT_W-1:0]      m_lo;
	logic [bmsf_pkg::BIT_W-1:0]      m_hi;
	logic [bmsf_pkg::WORD_W-1:0]     m_mask;

	logic [bmsf_pkg::SLOT_W-1:0]     base;
	logic [bmsf_pkg::SLOT_W-1:0]     rem;
	logic                            full;
	logic [bmsf_pkg::CNT_W-1:0]      cnt;
	logic                            found;
	logic [bmsf_pkg::BIT_W-1:0]      idx;
	logic [bmsf_pkg::SLOT_W-1:0]     c_f;
	logic [bmsf_pkg::SLOT_W-1:0]     c_nf;
	logic                            at_end;
	logic [bmsf_pkg::SLOT_W-1:0]     c_next;
	logic [bmsf_pkg::SLOT_W-1:0]     rlen_new;
	logic                            scan_end;

	assign size = (num_slots_q < bmsf_pkg::SLOT_W'(bmsf_pkg::MAX_SLOTS))
		? num_slots_q : bmsf_pkg::SLOT_W'(bmsf_pkg::MAX_SLOTS);

	assign s_ext   = bmsf_pkg::SLOT_W'(start_slot);
	assign len_sat = (length > bmsf_pkg::LEN_W'(bmsf_pkg::MAX_OBJECT_SLOTS))
		? bmsf_pkg::LEN_W'(bmsf_pkg::MAX_OBJECT_SLOTS) : length;
	assign s_plus  = s_ext + bmsf_pkg::SLOT_W'(len_sat);
	assign e_new   = (s_plus < size) ? s_plus : size;
	assign off     = s_ext >= size;
	assign cursor_end = cursor_q >= size;
	assign end_w   = bmsf_pkg::WIDX_W'((size - bmsf_pkg::SLOT_W'(1)) >> bmsf_pkg::BIT_W);

	assign word = valid_q[w_q] ? rdata_q : '0;

	assign em1       = mark_e_q - bmsf_pkg::SLOT_W'(1);
	assign mark_last = w_q == bmsf_pkg::WIDX_W'(em1 >> bmsf_pkg::BIT_W);
	assign m_lo      = (w_q == bmsf_pkg::WIDX_W'(mark_s_q >> bmsf_pkg::BIT_W))
		? mark_s_q[bmsf_pkg::BIT_W-1:0] : '0;
	assign m_hi      = mark_last ? em1[bmsf_pkg::BIT_W-1:0] : '1;
	assign m_mask    = (bmsf_pkg::WORD_ONES << m_lo)
		& (bmsf_pkg::WORD_ONES >> (bmsf_pkg::BIT_W'(bmsf_pkg::WORD_W - 1) - m_hi));

	assign base = bmsf_pkg::SLOT_W'({w_q, bmsf_pkg::BIT_W'(0)});
	assign rem  = size - base;
	assign full = rem >= bmsf_pkg::SLOT_W'(bmsf_pkg::WORD_W);
	assign cnt  = full ? bmsf_pkg::CNT_W'(bmsf_pkg::WORD_W) : bmsf_pkg::CNT_W'(rem);

	bmsf_find u_find (
		.data   (word),
		.lo     (cursor_q[bmsf_pkg::BIT_W-1:0]),
		.cnt    (cnt),
		.target (cmd.run),
		.found  (found),
		.idx    (idx)
	);

	assign c_f      = base + bmsf_pkg::SLOT_W'(idx);
	assign c_nf     = full ? base + bmsf_pkg::SLOT_W'(bmsf_pkg::WORD_W) : size;
	assign at_end   = c_nf >= size;
	assign c_next   = found ? c_f : c_nf;
	assign rlen_new = c_next - bmsf_pkg::SLOT_W'(rstart_q);
	assign scan_end = cmd.scan && !found && at_end;

	assign sts.in_op     = operation;
	assign sts.in_short  = (operation == bmsf_pkg::OP_SWEEP) ? cursor_end
		: (off || length == '0);
	assign sts.mark_last = mark_last;
	assign sts.found     = found;
	assign sts.at_end    = at_end;
	assign sts.out_free  = !out_valid_q || out_word.ready;

	always_ff @(posedge clk) begin
		if (cmd.mk_wr) begin
			mem[w_q] <= word | m_mask;
		end
		rdata_q <= mem[w_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			num_slots_q <= bmsf_pkg::SLOT_W'(bmsf_pkg::MAX_SLOTS);
			cursor_q    <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_slots_q <= cfg_data;
			end
			if (cmd.mk_wr) begin
				valid_q[w_q] <= 1'b1;
			end
			if (cmd.scan) begin
				cursor_q <= c_next;
				if (!found && full) begin
					valid_q[w_q] <= 1'b0;
				end
				if (cmd.run && (found || at_end)) begin
					free_q <= free_q + rlen_new;
				end
			end
			if (scan_end || (cmd.accept && operation == bmsf_pkg::OP_SWEEP
				&& cursor_end && size != '0)) begin
				valid_q[end_w] <= 1'b0;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				if (res_done_q) begin
					cursor_q <= '0;
					free_q   <= '0;
				end
			end else if (out_word.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_q         <= (operation == bmsf_pkg::OP_SWEEP)
				? bmsf_pkg::WIDX_W'(cursor_q >> bmsf_pkg::BIT_W)
				: bmsf_pkg::WIDX_W'(start_slot >> bmsf_pkg::BIT_W);
			mark_s_q    <= start_slot;
			mark_e_q    <= e_new;
			rstart_q    <= '0;
			rlen_q      <= '0;
			res_valid_q <= 1'b0;
			res_done_q  <= (operation == bmsf_pkg::OP_SWEEP) && cursor_end;
			res_offh_q  <= (operation == bmsf_pkg::OP_MARK) && off;
		end
		if (cmd.mk_wr && !mark_last) begin
			w_q <= w_q + bmsf_pkg::WIDX_W'(1);
		end
		if (cmd.scan) begin
			if (!found && !at_end) begin
				w_q <= w_q + bmsf_pkg::WIDX_W'(1);
			end
			if (!cmd.run && found) begin
				rstart_q <= bmsf_pkg::START_W'(c_f);
			end
			if (cmd.run && (found || at_end)) begin
				rlen_q      <= rlen_new;
				res_valid_q <= 1'b1;
			end
			if (scan_end) begin
				res_done_q <= 1'b1;
			end
		end
		if (cmd.fin) begin
			run_valid_q  <= res_valid_q;
			run_start_q  <= rstart_q;
			run_length_q <= rlen_q;
			sweep_done_q <= res_done_q;
			free_total_q <= free_q;
			off_heap_q   <= res_offh_q;
		end
	end

	assign out_word.valid      = out_valid_q;
	assign out_word.run_valid  = run_valid_q;
	assign out_word.run_start  = run_start_q;
	assign out_word.run_length = run_length_q;
	assign out_word.sweep_done = sweep_done_q;
	assign out_word.free_total = free_total_q;
	assign out_word.off_heap   = off_heap_q;

endmodule

>>> src/bmsf_ctrl.sv
// ----------------------------------------------------------------------------
// bmsf_ctrl: request sequencer
// Steps a mark through its bitmap words and a sweep through its skip and run
// phases, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bmsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bmsf_pkg::sts_t sts,
	output bmsf_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_M_RD  = 8'b0000_0010,
		ST_M_WR  = 8'b0000_0100,
		ST_S_RD  = 8'b0000_1000,
		ST_SKIP  = 8'b0001_0000,
		ST_R_RD  = 8'b0010_0000,
		ST_RUN   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.in_short) begin
						state_d = ST_FIN;
					end else if (sts.in_op == bmsf_pkg::OP_SWEEP) begin
						state_d = ST_S_RD;
					end else begin
						state_d = ST_M_RD;
					end
				end
			end
			ST_M_RD: begin
				state_d = ST_M_WR;
			end
			ST_M_WR: begin
				cmd.mk_wr = 1'b1;
				state_d   = sts.mark_last ? ST_FIN : ST_M_RD;
			end
			ST_S_RD: begin
				state_d = ST_SKIP;
			end
			ST_SKIP: begin
				cmd.scan = 1'b1;
				if (sts.found) begin
					state_d = ST_RUN;
				end else if (sts.at_end) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_S_RD;
				end
			end
			ST_R_RD: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.scan = 1'b1;
				cmd.run  = 1'b1;
				state_d  = (sts.found || sts.at_end) ? ST_FIN : ST_R_RD;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> tb/sv/tb_bitmap_mark_sweep_free_runs.sv
// ----------------------------------------------------------------------------
// tb_bitmap_mark_sweep_free_runs: self-checking bench for the liveness bitmap
// Feeds mark and sweep words through the input channel and keeps a shadow
// copy of the bitmap, sweep cursor and free total. Each result word is
// compared field by field with the shadow's answer. Several heap sizes are
// covered, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_mark_sweep_free_runs;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                         op;
		logic [bmsf_pkg::START_W-1:0] start_slot;
		logic [bmsf_pkg::LEN_W-1:0]   length;
		logic                         drain;
	} heap_req_t;

	typedef struct packed {
		logic                         run_valid;
		logic [bmsf_pkg::START_W-1:0] run_start;
		logic [bmsf_pkg::SLOT_W-1:0]  run_length;
		logic                         sweep_done;
		logic [bmsf_pkg::SLOT_W-1:0]  free_total;
		logic                         off_heap;
	} sweep_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we   = 1'b0;
	logic [bmsf_pkg::SLOT_W-1:0] cfg_data = '0;

	bmsf_in_if  in_word ();
	bmsf_out_if out_word ();

	bitmap_mark_sweep_free_runs dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_word  (in_word),
		.out_word (out_word)
	);

	// Shadow state of the block.
	logic [bmsf_pkg::WORD_W-1:0] live_map [bmsf_pkg::WORD_COUNT];
	int unsigned                 scan_pos;
	int unsigned                 free_sum;
	logic [bmsf_pkg::SLOT_W-1:0] heap_slots;

	heap_req_t     req_backlog [$];
	sweep_result_t due_results [$];
	heap_req_t     in_flight;

	bit quiet_phase;
	int send_gap;
	int stall_left;
	int mismatch_count;
	int queued_count;
	int mark_count;
	int sweep_count;
	int done_count;
	int off_heap_count;
	int size_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int draw_gap();
		int r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned step_past(int unsigned s);
		if ((s & 32'h1f) == 32'h1f)
			live_map[s >> 5] = '0;
		return s + 1;
	endfunction

	function automatic sweep_result_t apply_heap_request(heap_req_t rq);
		int unsigned size, s, n, c;
		sweep_result_t r;
		size = (heap_slots > bmsf_pkg::MAX_SLOTS) ? bmsf_pkg::MAX_SLOTS : heap_slots;
		r = '0;
		if (rq.op == bmsf_pkg::OP_MARK) begin
			s = 32'(rq.start_slot);
			n = 32'(rq.length);
			if (n > bmsf_pkg::MAX_OBJECT_SLOTS)
				n = bmsf_pkg::MAX_OBJECT_SLOTS;
			if (s >= size) begin
				r.off_heap = 1'b1;
			end else begin
				while (n > 0 && s < size) begin
					live_map[s >> 5][s & 32'h1f] = 1'b1;
					s++;
					n--;
				end
			end
		end else begin
			c = scan_pos;
			while (c < size && live_map[c >> 5][c & 32'h1f])
				c = step_past(c);
			if (c < size) begin
				r.run_start = c[bmsf_pkg::START_W-1:0];
				while (c < size && !live_map[c >> 5][c & 32'h1f])
					c = step_past(c);
				r.run_length = bmsf_pkg::SLOT_W'(c - 32'(r.run_start));
				r.run_valid = 1'b1;
				free_sum += c - 32'(r.run_start);
			end
			if (c >= size) begin
				r.sweep_done = 1'b1;
				if (size > 0)
					live_map[(size - 1) >> 5] = '0;
			end
			scan_pos = c;
		end
		r.free_total = free_sum[bmsf_pkg::SLOT_W-1:0];
		if (r.sweep_done) begin
			scan_pos = 0;
			free_sum = 0;
		end
		return r;
	endfunction

	task automatic report(string field, logic [bmsf_pkg::SLOT_W-1:0] got,
		logic [bmsf_pkg::SLOT_W-1:0] want);
		if (mismatch_count < 40)
			$display("%0t: %s is %0d, %0d expected", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Input driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word.valid      <= 1'b0;
			in_word.operation  <= bmsf_pkg::OP_MARK;
			in_word.start_slot <= '0;
			in_word.length     <= '0;
			send_gap = 0;
		end else begin
			if (in_word.valid && in_word.ready)
				due_results.push_back(apply_heap_request(in_flight));
			if (!in_word.valid || in_word.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_word.valid <= 1'b0;
				end else if (req_backlog.size() > 0 &&
						(!req_backlog[0].drain || due_results.size() == 0)) begin
					in_flight = req_backlog.pop_front();
					in_word.valid      <= 1'b1;
					in_word.operation  <= in_flight.op;
					in_word.start_slot <= in_flight.start_slot;
					in_word.length     <= in_flight.length;
					send_gap = draw_gap();
				end else begin
					in_word.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		sweep_result_t want;
		if (!arst_n) begin
			out_word.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_word.valid && out_word.ready) begin
				if (due_results.size() == 0) begin
					report("unexpected result word", bmsf_pkg::SLOT_W'(1),
						bmsf_pkg::SLOT_W'(0));
				end else begin
					want = due_results.pop_front();
					if (out_word.run_valid !== want.run_valid)
						report("run_valid", bmsf_pkg::SLOT_W'(out_word.run_valid),
							bmsf_pkg::SLOT_W'(want.run_valid));
					if (out_word.run_start !== want.run_start)
						report("run_start", bmsf_pkg::SLOT_W'(out_word.run_start),
							bmsf_pkg::SLOT_W'(want.run_start));
					if (out_word.run_length !== want.run_length)
						report("run_length", out_word.run_length, want.run_length);
					if (out_word.sweep_done !== want.sweep_done)
						report("sweep_done", bmsf_pkg::SLOT_W'(out_word.sweep_done),
							bmsf_pkg::SLOT_W'(want.sweep_done));
					if (out_word.free_total !== want.free_total)
						report("free_total", out_word.free_total, want.free_total);
					if (out_word.off_heap !== want.off_heap)
						report("off_heap", bmsf_pkg::SLOT_W'(out_word.off_heap),
							bmsf_pkg::SLOT_W'(want.off_heap));
					done_count     += int'(want.sweep_done);
					off_heap_count += int'(want.off_heap);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_word.ready <= 1'b0;
			end else begin
				out_word.ready <= 1'b1;
				stall_left = draw_gap();
			end
		end
	end

	task automatic add_req(logic op, int start, int len, bit drain = 1'b0);
		heap_req_t rq;
		rq.op         = op;
		rq.start_slot = start[bmsf_pkg::START_W-1:0];
		rq.length     = len[bmsf_pkg::LEN_W-1:0];
		rq.drain      = drain;
		req_backlog.push_back(rq);
		queued_count++;
		if (op == bmsf_pkg::OP_MARK)
			mark_count++;
		else
			sweep_count++;
	endtask

	task automatic add_random_mark(int unsigned size);
		int start, len, r;
		if (size == 0 || $urandom_range(0, 99) < 8)
			start = (size > 4095) ? $urandom_range(0, 4095) : $urandom_range(size, 4095);
		else
			start = $urandom_range(0, size - 1);
		r = $urandom_range(0, 99);
		if (r < 5)
			len = 0;
		else if (r < 15)
			len = $urandom_range(257, 511);
		else if (r < 30)
			len = $urandom_range(17, 256);
		else
			len = $urandom_range(1, 16);
		add_req(bmsf_pkg::OP_MARK, start, len, $urandom_range(0, 59) == 0);
	endtask

	task automatic add_random_sweep();
		add_req(bmsf_pkg::OP_SWEEP, $urandom_range(0, 4095), $urandom_range(0, 511),
			$urandom_range(0, 59) == 0);
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || in_word.valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_heap_size(int value);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_we     <= 1'b1;
		cfg_data   <= value[bmsf_pkg::SLOT_W-1:0];
		heap_slots = value[bmsf_pkg::SLOT_W-1:0];
		size_count++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(int value, int budget);
		int unsigned size;
		int target, k;
		size = (value > bmsf_pkg::MAX_SLOTS) ? bmsf_pkg::MAX_SLOTS : value;
		quiet_phase = ($urandom_range(0, 3) == 0);
		target = queued_count + budget;
		while (queued_count < target) begin
			if ($urandom_range(0, 99) < 80) begin
				k = $urandom_range(0, 12);
				repeat (k) add_random_mark(size);
				repeat (k + $urandom_range(1, 3)) add_random_sweep();
			end else begin
				repeat ($urandom_range(3, 15)) begin
					if ($urandom_range(0, 1))
						add_random_mark(size);
					else
						add_random_sweep();
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		int sizes [9];
		int idx;
		sizes = '{4096, 32, 31, 33, 1, 0, 8191, 100, 4095};
		for (idx = 0; idx < bmsf_pkg::WORD_COUNT; idx++)
			live_map[idx] = '0;
		scan_pos   = 0;
		free_sum   = 0;
		heap_slots = 13'd4096;
		quiet_phase = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words on the full heap after reset, then with heap sizes 0, 1 and 8191.
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		add_req(bmsf_pkg::OP_MARK, 0, 0);
		add_req(bmsf_pkg::OP_MARK, 4095, 511);
		add_req(bmsf_pkg::OP_MARK, 0, 256);
		add_req(bmsf_pkg::OP_MARK, 100, 1);
		add_req(bmsf_pkg::OP_MARK, 300, 300);
		add_req(bmsf_pkg::OP_MARK, 31, 2);
		add_req(bmsf_pkg::OP_SWEEP, 4095, 511);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0, 1'b1);
		wait_idle();
		write_heap_size(0);
		add_req(bmsf_pkg::OP_MARK, 0, 1);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		wait_idle();
		write_heap_size(1);
		add_req(bmsf_pkg::OP_MARK, 0, 511);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		add_req(bmsf_pkg::OP_MARK, 1, 1);
		add_req(bmsf_pkg::OP_MARK, 4095, 1);
		wait_idle();
		write_heap_size(8191);
		add_req(bmsf_pkg::OP_MARK, 4064, 256);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		add_req(bmsf_pkg::OP_SWEEP, 0, 0);
		wait_idle();

		// Random phases over a spread of heap sizes.
		foreach (sizes[i]) begin
			write_heap_size(sizes[i]);
			random_phase(sizes[i], 60);
		end
		while (queued_count < 825) begin
			if ($urandom_range(0, 4) == 0)
				idx = $urandom_range(0, 8191);
			else
				idx = $urandom_range(1, 4096);
			write_heap_size(idx);
			random_phase(idx, 60);
		end

		wait_idle();
		repeat (40) @(posedge clk);
		$display("Covered %0d words: %0d marks (%0d off the heap), %0d sweeps.",
			queued_count, mark_count, off_heap_count, sweep_count);
		$display("Sweeps completed %0d times over %0d heap size settings.",
			done_count, size_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d words queued and %0d results outstanding.",
			req_backlog.size(), due_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> bitmap_mark_sweep_free_runs.f
src/bmsf_pkg.sv
src/bmsf_in_if.sv
src/bmsf_out_if.sv
src/bmsf_find.sv
src/bmsf_dp.sv
src/bmsf_ctrl.sv
src/bitmap_mark_sweep_free_runs.sv
tb/sv/tb_bitmap_mark_sweep_free_runs.sv
